// ===== hdl/msp_pkg.sv =====
// ----------------------------------------------------------------------------
// Multi-stack shared pool package
// Pointer format, operation and status codes, and register indexes.
// ----------------------------------------------------------------------------
package msp_pkg;

  localparam int PTR_W  = 7;
  localparam int DATA_W = 32;
  localparam int CFG_W  = 7;
  localparam int CFG_IDX_W = 2;

  localparam logic [PTR_W-1:0] NIL = '1;

  localparam logic [1:0] OP_PUSH    = 2'd0;
  localparam logic [1:0] OP_POP     = 2'd1;
  localparam logic [1:0] OP_DISPLAY = 2'd2;
  localparam logic [1:0] OP_NONE    = 2'd3;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_OVERFLOW = 2'd1;
  localparam logic [1:0] STAT_EMPTY    = 2'd2;
  localparam logic [1:0] STAT_INVALID  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_POOL_SIZE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STACK_COUNT = 2'd1;

  typedef logic [PTR_W-1:0] ptr_t;

  // A pointer names a live slot when it is below the active pool size.
  function automatic logic ptr_ok(input ptr_t p, input ptr_t active);
    return (p != NIL) && (p < active);
  endfunction

endpackage

// ===== hdl/multi_stack_shared_pool.sv =====
// ----------------------------------------------------------------------------
// Multi-stack shared pool
// Several LIFO stacks linked through one pool of slots with a common free list.
// ----------------------------------------------------------------------------
// Usage: an operation (push, pop or display of one stack) is taken at a clock
// edge where start is high and busy is low. Every result appears for exactly
// one cycle with result_valid high, together with status, read_value and last;
// the receiver cannot stall, so results are never held back. last marks the
// final result of an operation.
// Flow: a rejected operation (bad opcode, stack out of range, overflow or
// empty stack) gives its result in the cycle after the transfer and the block
// stays ready. A push or a pop reads the link and value memories at the
// transfer and writes back from its own state, which also registers its
// result; the block stays busy until then, so a new operation can only be
// taken once that result is out. A display of n elements gives n results,
// one result a cycle, paced by the read of the link memory.
// Configuration: cfg_write with cfg_index 0 (pool size) or 1 (stack count)
// empties all stacks at once; no memory sweep is needed, since slots that have
// not been handed out since then take their free-list link from a watermark.
// Reset: synchronous; gives a pool of 64 slots, 8 stacks, all empty.
// ----------------------------------------------------------------------------
module multi_stack_shared_pool
  import msp_pkg::*;
#(
  parameter int SLOTS  = 64,
  parameter int STACKS = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               opcode,
  input  logic [2:0]               stack_index,
  input  logic signed [DATA_W-1:0] push_value,
  input  logic                     cfg_write,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  output logic                     result_valid,
  output logic [1:0]               status,
  output logic signed [DATA_W-1:0] read_value,
  output logic                     last
);

  localparam int AW = $clog2(SLOTS);
  localparam int HW = (STACKS > 1) ? $clog2(STACKS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PUSH = 2'd1;
  localparam logic [1:0] ST_POP  = 2'd2;
  localparam logic [1:0] ST_WALK = 2'd3;

  logic [1:0]        state;
  logic [CFG_W-1:0]  pool_size;
  logic [3:0]        stack_count;
  ptr_t              heads [STACKS];
  ptr_t              free_head;
  ptr_t              fresh;
  ptr_t              cur_ptr;
  ptr_t              head_q;
  logic [HW-1:0]     stack_q;
  logic [DATA_W-1:0] value_q;
  logic [CW-1:0]     walk_cnt;

  logic [DATA_W-1:0] value_mem [SLOTS];
  ptr_t              link_mem  [SLOTS];
  logic [DATA_W-1:0] value_rd;
  ptr_t              link_rd;

  ptr_t          active_slots;
  logic [4:0]    active_stacks;
  logic [7:0]    stack_wide;
  logic [HW-1:0] stack_sel;
  ptr_t          head_sel;
  logic          op_valid;
  ptr_t          next_fresh;
  ptr_t          link_eff;
  logic          walk_fin;
  logic          accept;
  logic          rd_en;
  ptr_t          rd_ptr;
  logic          link_we;
  ptr_t          link_wd;
  logic          value_we;

  assign busy = (state != ST_IDLE);
  assign accept = start && !busy;

  assign active_slots  = (pool_size > 7'(SLOTS)) ? 7'(SLOTS) : pool_size;
  assign active_stacks = ({1'b0, stack_count} > 5'(STACKS)) ? 5'(STACKS)
                                                            : {1'b0, stack_count};

  assign stack_wide = 8'(stack_index);
  assign stack_sel  = stack_wide[HW-1:0];
  assign head_sel   = heads[stack_sel];
  assign op_valid   = (opcode != OP_NONE) && ({2'b00, stack_index} < active_stacks);

  // Slots at or above the watermark have not been handed out since the last
  // rebuild, so their link is still the ascending free-list chain.
  assign next_fresh = cur_ptr + 7'd1;
  assign link_eff = (cur_ptr >= fresh)
                  ? ((next_fresh < active_slots) ? next_fresh : NIL)
                  : link_rd;

  assign walk_fin = !ptr_ok(link_eff, active_slots)
                 || ({1'b0, walk_cnt} + (CW+1)'(1) >= (CW+1)'(SLOTS));

  always_comb begin
    rd_en  = 1'b0;
    rd_ptr = link_eff;
    if (state == ST_IDLE) begin
      rd_ptr = (opcode == OP_PUSH) ? free_head : head_sel;
      rd_en  = accept && op_valid && ptr_ok(rd_ptr, active_slots);
    end else if (state == ST_WALK) begin
      rd_en = !walk_fin;
    end
  end

  assign link_we  = (state == ST_PUSH) || (state == ST_POP);
  assign link_wd  = (state == ST_PUSH) ? head_q : free_head;
  assign value_we = (state == ST_PUSH);

  always_ff @(posedge clk) begin
    if (value_we) begin
      value_mem[cur_ptr[AW-1:0]] <= value_q;
    end
    if (link_we) begin
      link_mem[cur_ptr[AW-1:0]] <= link_wd;
    end
    if (rd_en) begin
      value_rd <= value_mem[rd_ptr[AW-1:0]];
      link_rd  <= link_mem[rd_ptr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && accept) begin
      stack_q <= stack_sel;
      head_q  <= head_sel;
      value_q <= push_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      pool_size    <= 7'd64;
      stack_count  <= 4'd8;
      free_head    <= '0;
      fresh        <= '0;
      cur_ptr      <= '0;
      walk_cnt     <= '0;
      result_valid <= 1'b0;
      status       <= STAT_OK;
      read_value   <= '0;
      last         <= 1'b0;
      for (int i = 0; i < STACKS; i++) begin
        heads[i] <= NIL;
      end
    end else begin
      result_valid <= 1'b0;
      if (cfg_write && (cfg_index == REG_POOL_SIZE || cfg_index == REG_STACK_COUNT)) begin
        if (cfg_index == REG_POOL_SIZE) begin
          pool_size <= cfg_data;
        end else begin
          stack_count <= cfg_data[3:0];
        end
        // Slot 0 heads the free list; with an empty pool it fails the
        // live-slot check just as a null pointer would.
        free_head <= '0;
        fresh     <= '0;
        for (int i = 0; i < STACKS; i++) begin
          heads[i] <= NIL;
        end
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            result_valid <= 1'b1;
            read_value   <= '0;
            last         <= 1'b1;
            status       <= STAT_INVALID;
            if (op_valid) begin
              if (opcode == OP_PUSH) begin
                if (ptr_ok(free_head, active_slots)) begin
                  result_valid <= 1'b0;
                  cur_ptr      <= free_head;
                  state        <= ST_PUSH;
                end else begin
                  status <= STAT_OVERFLOW;
                end
              end else if (ptr_ok(head_sel, active_slots)) begin
                result_valid <= 1'b0;
                cur_ptr      <= head_sel;
                walk_cnt     <= '0;
                state        <= (opcode == OP_POP) ? ST_POP : ST_WALK;
              end else begin
                status <= STAT_EMPTY;
              end
            end
          end
        end
        ST_PUSH: begin
          free_head        <= link_eff;
          heads[stack_q]   <= cur_ptr;
          if (cur_ptr == fresh) begin
            fresh <= fresh + 7'd1;
          end
          result_valid <= 1'b1;
          status       <= STAT_OK;
          read_value   <= '0;
          last         <= 1'b1;
          state        <= ST_IDLE;
        end
        ST_POP: begin
          heads[stack_q] <= link_eff;
          free_head      <= cur_ptr;
          result_valid   <= 1'b1;
          status         <= STAT_OK;
          read_value     <= value_rd;
          last           <= 1'b1;
          state          <= ST_IDLE;
        end
        ST_WALK: begin
          result_valid <= 1'b1;
          status       <= STAT_OK;
          read_value   <= value_rd;
          last         <= walk_fin;
          cur_ptr      <= link_eff;
          walk_cnt     <= walk_cnt + CW'(1);
          if (walk_fin) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // The watermark never passes the end of the active pool.
  a_fresh_bound: assert property (@(posedge clk) disable iff (rst)
    fresh <= active_slots)
    else $error("free-list watermark beyond the active pool");

  // Every result stems from an accepted operation or one still in progress.
  a_result_cause: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(accept || busy))
    else $error("result without an operation");

  // A result that is not the final one is followed at once by the next one.
  a_walk_stream: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !last) |=> result_valid)
    else $error("display stream broken");

  // Once the final result is out, the block is ready again.
  a_last_ready: assert property (@(posedge clk) disable iff (rst)
    (result_valid && last) |-> !busy)
    else $error("block still busy after its final result");

endmodule
